[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i; ASSERT_CHK is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int TableDepthDef   = 16;
  localparam int PoolAddrBitsDef = 20;

  localparam int ReqLenW   = 21;
  localparam int OffW      = 20;
  localparam int PoolSizeW = 21;

  localparam logic [PoolSizeW-1:0] PoolSizeRst = 21'h100000;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HOLE   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [ReqLenW-1:0]  request_length;
    logic [OffW-1:0]     free_offset;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [OffW-1:0]     block_offset;
  } rsp_t;

  typedef logic [PoolSizeW-1:0] cfg_t;

endpackage

[hw/rtl/ffpa_stream_if.sv]
// ----------------------------------------------------------------------------
// ffpa_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface ffpa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ffpa_entry_mem.sv]
// ----------------------------------------------------------------------------
// ffpa_entry_mem
// Partition table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffpa_entry_mem #(
  parameter int Depth = ffpa_pkg::TableDepthDef,
  parameter int Width = 2 * ffpa_pkg::PoolAddrBitsDef + 1,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/first_fit_partition_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// First-fit allocator keeping a sorted table of partitions in a RAM.
// ----------------------------------------------------------------------------
// Channels: req_i takes one word per item (action, request_length,
// free_offset); rsp_o returns one word per item (status, block_offset);
// cfg_i writes pool_size and is always ready; the user must write it only
// while idle, as the block does not enforce this. An allocate walks the
// table one entry per cycle from the RAM read port, then moves the
// entries above the chosen slot up one place, one per cycle, and writes
// the new entry. A free walks to the matching entry and moves the entries
// above it down one place. A full table or a zero length skips the walk
// and goes straight to the response; a search that finds nothing walks
// every entry in the table. One item is at work at a time; the next is
// taken once the result sits in the output register.
// Reset empties the table at once (count cleared, no RAM pass) and sets
// pool_size to 1048576. A stalled rsp_o holds its word; a finished result
// waits in the block until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_partition_allocator #(
  parameter int TABLE_DEPTH       = ffpa_pkg::TableDepthDef,
  parameter int POOL_ADDRESS_BITS = ffpa_pkg::PoolAddrBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ffpa_stream_if.sink     req_i,
  ffpa_stream_if.source   rsp_o,
  ffpa_stream_if.sink     cfg_i
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int OW = POOL_ADDRESS_BITS;
  localparam int LW = POOL_ADDRESS_BITS + 1;
  localparam int EW = OW + LW;
  localparam int CW = (POOL_ADDRESS_BITS + 1 > ffpa_pkg::ReqLenW) ?
                      POOL_ADDRESS_BITS + 1 : ffpa_pkg::ReqLenW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_INSERT = 6'b001000,
    S_DOWN   = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [NW-1:0]          cnt_q, cnt_d;
  logic [NW-1:0]          ev_q, ev_d;
  logic [IW-1:0]          sh_q, sh_d;
  logic [IW-1:0]          slot_q, slot_d;
  logic [CW-1:0]          start_q, start_d;
  logic [CW-1:0]          len_q, len_d;
  logic [CW-1:0]          foff_q, foff_d;
  ffpa_pkg::action_e      act_q, act_d;
  logic [OW-1:0]          pos_q, pos_d;
  ffpa_pkg::rsp_t         pend_q, pend_d;
  ffpa_pkg::rsp_t         out_q, out_d;
  logic                   out_vld_q, out_vld_d;
  ffpa_pkg::cfg_t         pool_q, pool_d;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [EW-1:0]          mem_wdata;
  logic [IW-1:0]          mem_raddr;
  logic [EW-1:0]          mem_rdata;

  logic [OW-1:0]          rd_off;
  logic [LW-1:0]          rd_len;
  logic [CW-1:0]          cap;
  logic [CW-1:0]          pool_ext;
  logic [CW-1:0]          limit;
  logic [CW-1:0]          hole_end;
  logic [CW-1:0]          hole;
  logic [CW-1:0]          ent_end;
  logic [CW-1:0]          pos_ext;
  logic                   ev_last;
  logic                   fits;
  logic                   match;
  logic                   req_fire;
  logic                   out_free;

  assign rd_off   = mem_rdata[EW-1:LW];
  assign rd_len   = mem_rdata[LW-1:0];
  assign cap      = CW'(1) << POOL_ADDRESS_BITS;
  assign pool_ext = CW'(pool_q);
  assign limit    = (pool_ext > cap) ? cap : pool_ext;
  assign ev_last  = (ev_q == cnt_q);
  assign hole_end = ev_last ? limit : CW'(rd_off);
  assign hole     = (hole_end > start_q) ? (hole_end - start_q) : '0;
  assign fits     = (hole >= len_q);
  assign ent_end  = CW'(rd_off) + CW'(rd_len);
  assign match    = (CW'(rd_off) == foff_q);
  assign pos_ext  = CW'(pos_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ev_d      = ev_q;
    sh_d      = sh_q;
    slot_d    = slot_q;
    start_d   = start_q;
    len_d     = len_q;
    foff_d    = foff_q;
    act_d     = act_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    pool_d    = pool_q;
    mem_we    = 1'b0;
    mem_waddr = sh_q;
    mem_wdata = mem_rdata;
    mem_raddr = IW'(ev_q + NW'(1));

    if (cfg_i.valid) begin
      pool_d = cfg_i.data;
    end
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = '0;
        if (req_fire) begin
          act_d   = req_i.data.action;
          len_d   = CW'(req_i.data.request_length);
          foff_d  = CW'(req_i.data.free_offset);
          start_d = '0;
          ev_d    = '0;
          pend_d  = '{status: ffpa_pkg::ST_NO_HOLE, block_offset: '0};
          if (req_i.data.action == ffpa_pkg::ACT_ALLOC &&
              cnt_q == NW'(TABLE_DEPTH)) begin
            pend_d.status = ffpa_pkg::ST_FULL;
            state_d       = S_RESP;
          end else if (req_i.data.action == ffpa_pkg::ACT_ALLOC &&
                       req_i.data.request_length == '0) begin
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (act_q == ffpa_pkg::ACT_ALLOC) begin
          if (fits) begin
            slot_d = IW'(ev_q);
            pos_d  = OW'(start_q);
            if (ev_last) begin
              state_d = S_INSERT;
            end else begin
              mem_raddr = IW'(cnt_q - NW'(1));
              sh_d      = IW'(cnt_q);
              state_d   = S_SHIFT;
            end
          end else if (ev_last) begin
            pend_d.status = ffpa_pkg::ST_NO_HOLE;
            state_d       = S_RESP;
          end else begin
            if (ent_end > start_q) begin
              start_d = ent_end;
            end
            ev_d = ev_q + NW'(1);
          end
        end else begin
          if (ev_last) begin
            pend_d.status = ffpa_pkg::ST_NOT_FOUND;
            state_d       = S_RESP;
          end else if (match) begin
            if ((NW + 1)'(ev_q) + (NW + 1)'(1) == (NW + 1)'(cnt_q)) begin
              cnt_d         = cnt_q - NW'(1);
              pend_d.status = ffpa_pkg::ST_OK;
              state_d       = S_RESP;
            end else begin
              sh_d    = IW'(ev_q);
              state_d = S_DOWN;
            end
          end else begin
            ev_d = ev_q + NW'(1);
          end
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = sh_q;
        mem_wdata = mem_rdata;
        if ({1'b0, sh_q} == {1'b0, slot_q} + (IW + 1)'(1)) begin
          state_d = S_INSERT;
        end else begin
          mem_raddr = IW'({1'b0, sh_q} - (IW + 1)'(2));
          sh_d      = IW'({1'b0, sh_q} - (IW + 1)'(1));
        end
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        mem_wdata = {pos_q, LW'(len_q)};
        cnt_d     = cnt_q + NW'(1);
        pend_d    = '{status: ffpa_pkg::ST_OK,
                      block_offset: pos_ext[ffpa_pkg::OffW-1:0]};
        state_d   = S_RESP;
      end
      S_DOWN: begin
        mem_we    = 1'b1;
        mem_waddr = sh_q;
        mem_wdata = mem_rdata;
        if ((NW + 1)'(sh_q) + (NW + 1)'(2) == (NW + 1)'(cnt_q)) begin
          cnt_d         = cnt_q - NW'(1);
          pend_d.status = ffpa_pkg::ST_OK;
          state_d       = S_RESP;
        end else begin
          mem_raddr = IW'({1'b0, sh_q} + (IW + 1)'(2));
          sh_d      = IW'({1'b0, sh_q} + (IW + 1)'(1));
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_d     = pend_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      pool_q    <= ffpa_pkg::PoolSizeRst;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      pool_q    <= pool_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q    <= ev_d;
    sh_q    <= sh_d;
    slot_q  <= slot_d;
    start_q <= start_d;
    len_q   <= len_d;
    foff_q  <= foff_d;
    act_q   <= act_d;
    pos_q   <= pos_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  ffpa_entry_mem #(
    .Depth (TABLE_DEPTH),
    .Width (EW),
    .AddrW (IW)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= NW'(TABLE_DEPTH), "entry count above table depth")
  `ASSERT_CHK(a_accept_busy, req_fire |=> state_q != S_IDLE, "accepted word left block idle")
  `ASSERT_CHK(a_cnt_hold, !(state_q == S_INSERT || state_q == S_DOWN || state_q == S_SCAN) |=> $stable(cnt_q), "entry count moved outside update")
  `ASSERT_CHK(a_resp_wait, (state_q == S_RESP && out_vld_q && !rsp_o.ready) |=> state_q == S_RESP, "result dropped while output stalled")

endmodule
